>>> src/framed_ascii_decimal_receiver_assert.svh
// assertion macros for the framed ascii decimal receiver
`ifndef FRAMED_ASCII_DECIMAL_RECEIVER_ASSERT_SVH
`define FRAMED_ASCII_DECIMAL_RECEIVER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FADR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define FADR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/fadr_pkg.sv
// shared widths and defaults of the framed ascii decimal receiver
package fadr_pkg;

    localparam int unsigned BYTE_W               = 8;
    localparam int unsigned FIRST_W              = 17;
    localparam int unsigned VALUE_W              = 16;
    localparam int unsigned NFIELD_W             = 2;
    localparam int unsigned APB_DATA_W           = 32;
    localparam int unsigned APB_ADDR_W           = 5;
    localparam int unsigned BUFFER_DEPTH_DEFAULT = 64;
    localparam logic [BYTE_W-1:0] OFFSET_RESET   = 8'd45;

endpackage

>>> src/fadr_rx_if.sv
// received word channel: channel tag and byte
interface fadr_rx_if;
    logic                           valid;
    logic                           ready;
    logic                           channel;
    logic [fadr_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output channel, output rx_byte, input ready);
    modport sink   (input valid, input channel, input rx_byte, output ready);
endinterface

>>> src/fadr_res_if.sv
// result word channel: parsed values of a completed packet
interface fadr_res_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   source_channel;
    logic signed [fadr_pkg::FIRST_W-1:0]    first_value;
    logic signed [fadr_pkg::VALUE_W-1:0]    second_value;
    logic [fadr_pkg::NFIELD_W-1:0]          fields_parsed;

    modport source (output valid, output source_channel, output first_value,
                    output second_value, output fields_parsed, input ready);
    modport sink   (input valid, input source_channel, input first_value,
                    input second_value, input fields_parsed, output ready);
endinterface

>>> src/framed_ascii_decimal_receiver.sv
// framed ascii decimal receiver: two-channel packet framing and integer parsing
// The block takes one received word per clock: a channel tag and a byte. Each
// channel waits for its head byte, collects payload up to BUFFER_DEPTH bytes
// (later payload bytes are dropped) and closes on its tail byte; the payload
// is parsed on the fly like scanf %d (whitespace, optional sign, digits).
// Channel 0 expects "int,int", channel 1 one int. On a tail with at least 3
// (channel 0) or 2 (channel 1) kept bytes one result word is produced;
// values saturate to int16 and channel 0's first value has first_value_offset
// subtracted. Throughput is one word per cycle while no result stalls: a word is registered on
// entry, then a single pass of logic (the times-ten accumulate, saturation
// and the offset subtract) updates the channel state and loads the result
// register as the tail word leaves the input register.
// The input keeps flowing while a result waits; only a tail that produces a
// result stalls behind an untaken result. Registers (APB, byte address 4*i):
// 0 head_byte_zero, 1 tail_byte_zero, 2 head_byte_one, 3 tail_byte_one,
// 4 first_value_offset; write them only while the block is idle.
module framed_ascii_decimal_receiver #(
    parameter int unsigned BUFFER_DEPTH = fadr_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    fadr_rx_if.sink                             i_rx,
    fadr_res_if.source                          o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fadr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [fadr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fadr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int unsigned CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned BW     = fadr_pkg::BYTE_W;
    localparam int unsigned VW     = fadr_pkg::VALUE_W;
    localparam int unsigned FW     = fadr_pkg::FIRST_W;
    localparam int unsigned ACC_W  = VW + 1;
    localparam int unsigned PROD_W = ACC_W + 3;

    // register indexes
    localparam logic [2:0] REG_HEAD_ZERO = 3'd0;
    localparam logic [2:0] REG_TAIL_ZERO = 3'd1;
    localparam logic [2:0] REG_HEAD_ONE  = 3'd2;
    localparam logic [2:0] REG_TAIL_ONE  = 3'd3;
    localparam logic [2:0] REG_OFFSET    = 3'd4;

    // ascii codes
    localparam logic [BW-1:0] ASC_NUL   = 8'd0;
    localparam logic [BW-1:0] ASC_TAB   = 8'd9;
    localparam logic [BW-1:0] ASC_CR    = 8'd13;
    localparam logic [BW-1:0] ASC_SPACE = 8'd32;
    localparam logic [BW-1:0] ASC_PLUS  = 8'd43;
    localparam logic [BW-1:0] ASC_COMMA = 8'd44;
    localparam logic [BW-1:0] ASC_MINUS = 8'd45;
    localparam logic [BW-1:0] ASC_ZERO  = 8'd48;
    localparam logic [BW-1:0] ASC_NINE  = 8'd57;

    localparam logic [ACC_W-1:0] MAG_CAP = 17'd32768;
    localparam logic [ACC_W-1:0] POS_MAX = 17'd32767;
    localparam logic [VW-1:0]    SAT_POS = 16'h7FFF;

    localparam logic [CNT_W-1:0] MIN_PAYLOAD_ZERO = CNT_W'(3);
    localparam logic [CNT_W-1:0] MIN_PAYLOAD_ONE  = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_MAX          = CNT_W'(BUFFER_DEPTH);

    // parse phase of one channel
    typedef enum logic [6:0] {
        PH_SKIP1 = 7'b0000001,
        PH_SIGN1 = 7'b0000010,
        PH_DIG1  = 7'b0000100,
        PH_SKIP2 = 7'b0001000,
        PH_SIGN2 = 7'b0010000,
        PH_DIG2  = 7'b0100000,
        PH_DONE  = 7'b1000000
    } t_phase;

    // configuration
    logic [BW-1:0] r_head0, r_tail0, r_head1, r_tail1, r_offset;
    logic          w_cfg_wr;
    logic [2:0]    w_cfg_idx;

    // input register
    logic          r_s1_valid;
    logic          r_s1_ch;
    logic [BW-1:0] r_s1_byte;
    logic          w_in_fire;
    logic          w_s1_fire;

    // per-channel state
    logic [1:0]                r_inpk,        n_inpk;
    logic [1:0][CNT_W-1:0]     r_cnt,         n_cnt;
    t_phase                    r_phase [2];
    t_phase                    n_phase [2];
    logic [1:0][ACC_W-1:0]     r_acc,         n_acc;
    logic [1:0]                r_neg,         n_neg;
    logic [1:0][1:0]           r_mask,        n_mask;
    logic [1:0][VW-1:0]        r_pend_first,  n_pend_first;
    logic [VW-1:0]             r_pend_second, n_pend_second;
    logic [1:0][VW-1:0]        r_held_first,  n_held_first;
    logic [VW-1:0]             r_held_second, n_held_second;

    // result register
    logic          r_out_valid;
    logic          r_out_ch;
    logic [FW-1:0] r_out_first;
    logic [VW-1:0] r_out_second;
    logic [1:0]    r_out_nf;
    logic          w_out_free;

    // current-word decode
    logic            w_ch;
    logic [BW-1:0]   w_head, w_tail;
    logic            w_is_head, w_is_tail;
    logic            w_c_inpk, w_c_neg;
    logic [CNT_W-1:0] w_c_cnt;
    t_phase          w_c_ph;
    logic [ACC_W-1:0] w_c_acc;
    logic [1:0]      w_c_mask;
    logic            w_has_room, w_long_enough, w_emit;

    // feed path
    logic [BW-1:0]   w_fb;
    logic            w_fb_space, w_fb_digit, w_fb_sign;
    logic [3:0]      w_dval;
    logic [PROD_W-1:0] w_prod;
    logic [ACC_W-1:0] w_acc_next;
    logic [ACC_W-1:0] w_neg_mag;
    logic [VW-1:0]   w_fin;
    t_phase          f_ph;
    logic [ACC_W-1:0] f_acc;
    logic            f_neg;
    logic [1:0]      f_mask;
    logic [VW-1:0]   f_pfirst, f_psecond;

    // commit and result values
    logic [VW-1:0]   w_new_first, w_new_second;
    logic [FW-1:0]   w_res_first;
    logic [VW-1:0]   w_res_second;
    logic [1:0]      w_res_nf;

    // ---------------------------------------------------------------- apb
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head0  <= '0;
            r_tail0  <= '0;
            r_head1  <= '0;
            r_tail1  <= '0;
            r_offset <= fadr_pkg::OFFSET_RESET;
        end else if (w_cfg_wr) begin
            // indexes beyond the register list are ignored
            unique case (w_cfg_idx)
                REG_HEAD_ZERO: r_head0  <= pwdata[BW-1:0];
                REG_TAIL_ZERO: r_tail0  <= pwdata[BW-1:0];
                REG_HEAD_ONE:  r_head1  <= pwdata[BW-1:0];
                REG_TAIL_ONE:  r_tail1  <= pwdata[BW-1:0];
                REG_OFFSET:    r_offset <= pwdata[BW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_cfg_idx)
            REG_HEAD_ZERO: prdata[BW-1:0] = r_head0;
            REG_TAIL_ZERO: prdata[BW-1:0] = r_tail0;
            REG_HEAD_ONE:  prdata[BW-1:0] = r_head1;
            REG_TAIL_ONE:  prdata[BW-1:0] = r_tail1;
            REG_OFFSET:    prdata[BW-1:0] = r_offset;
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- input register
    // a waiting result only blocks a word that would produce another result
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_s1_fire   = r_s1_valid && (!w_emit || w_out_free);
    assign i_rx.ready  = !r_s1_valid || w_s1_fire;
    assign w_in_fire   = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_ch   <= i_rx.channel;
            r_s1_byte <= i_rx.rx_byte;
        end
    end

    // ---------------------------------------------------------------- framing decode
    assign w_ch       = r_s1_ch;
    assign w_head     = w_ch ? r_head1 : r_head0;
    assign w_tail     = w_ch ? r_tail1 : r_tail0;
    assign w_is_head  = (r_s1_byte == w_head);
    assign w_is_tail  = (r_s1_byte == w_tail);
    assign w_c_inpk   = r_inpk[w_ch];
    assign w_c_cnt    = r_cnt[w_ch];
    assign w_c_ph     = r_phase[w_ch];
    assign w_c_acc    = r_acc[w_ch];
    assign w_c_neg    = r_neg[w_ch];
    assign w_c_mask   = r_mask[w_ch];
    assign w_has_room = (w_c_cnt < CNT_MAX);
    assign w_long_enough = w_ch ? (w_c_cnt >= MIN_PAYLOAD_ONE)
                                : (w_c_cnt >= MIN_PAYLOAD_ZERO);
    assign w_emit     = w_c_inpk && w_is_tail && w_long_enough;

    // ---------------------------------------------------------------- parser step
    // the tail feeds a nul, which ends any number in progress
    assign w_fb       = w_is_tail ? ASC_NUL : r_s1_byte;
    assign w_fb_space = (w_fb == ASC_SPACE) || ((w_fb >= ASC_TAB) && (w_fb <= ASC_CR));
    assign w_fb_digit = (w_fb >= ASC_ZERO) && (w_fb <= ASC_NINE);
    assign w_fb_sign  = (w_fb == ASC_PLUS) || (w_fb == ASC_MINUS);
    assign w_dval     = 4'(w_fb - ASC_ZERO);

    // times ten as shift-add, then saturate the magnitude
    assign w_prod     = {w_c_acc, 3'b000} + PROD_W'({w_c_acc, 1'b0}) + PROD_W'(w_dval);
    assign w_acc_next = (w_prod > PROD_W'(MAG_CAP)) ? MAG_CAP : w_prod[ACC_W-1:0];

    assign w_neg_mag  = '0 - w_c_acc;
    assign w_fin      = w_c_neg ? w_neg_mag[VW-1:0]
                                : ((w_c_acc > POS_MAX) ? SAT_POS : w_c_acc[VW-1:0]);

    always_comb begin
        f_ph      = w_c_ph;
        f_acc     = w_c_acc;
        f_neg     = w_c_neg;
        f_mask    = w_c_mask;
        f_pfirst  = r_pend_first[w_ch];
        f_psecond = r_pend_second;
        unique case (w_c_ph)
            PH_SKIP1, PH_SKIP2: begin
                if (!w_fb_space) begin
                    if (w_fb_sign) begin
                        f_neg = (w_fb == ASC_MINUS);
                        f_ph  = (w_c_ph == PH_SKIP1) ? PH_SIGN1 : PH_SIGN2;
                    end else if (w_fb_digit) begin
                        f_acc = ACC_W'(w_dval);
                        f_ph  = (w_c_ph == PH_SKIP1) ? PH_DIG1 : PH_DIG2;
                    end else begin
                        f_ph = PH_DONE;
                    end
                end
            end
            PH_SIGN1, PH_SIGN2: begin
                if (w_fb_digit) begin
                    f_acc = ACC_W'(w_dval);
                    f_ph  = (w_c_ph == PH_SIGN1) ? PH_DIG1 : PH_DIG2;
                end else begin
                    f_ph = PH_DONE;
                end
            end
            PH_DIG1: begin
                if (w_fb_digit) begin
                    f_acc = w_acc_next;
                end else begin
                    f_pfirst  = w_fin;
                    f_mask[0] = 1'b1;
                    // only channel 0 goes on to a second field
                    if (!w_ch && (w_fb == ASC_COMMA)) begin
                        f_ph  = PH_SKIP2;
                        f_acc = '0;
                        f_neg = 1'b0;
                    end else begin
                        f_ph = PH_DONE;
                    end
                end
            end
            PH_DIG2: begin
                if (w_fb_digit) begin
                    f_acc = w_acc_next;
                end else begin
                    f_psecond = w_fin;
                    f_mask[1] = 1'b1;
                    f_ph      = PH_DONE;
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- commit and result
    assign w_new_first  = f_mask[0] ? f_pfirst : r_held_first[w_ch];
    assign w_new_second = f_mask[1] ? f_psecond : r_held_second;
    assign w_res_first  = {w_new_first[VW-1], w_new_first}
                          - (w_ch ? '0 : FW'(r_offset));
    assign w_res_second = w_ch ? '0 : w_new_second;
    assign w_res_nf     = 2'(f_mask[0]) + 2'(!w_ch && f_mask[1]);

    always_comb begin
        n_inpk        = r_inpk;
        n_cnt         = r_cnt;
        n_phase       = r_phase;
        n_acc         = r_acc;
        n_neg         = r_neg;
        n_mask        = r_mask;
        n_pend_first  = r_pend_first;
        n_pend_second = r_pend_second;
        n_held_first  = r_held_first;
        n_held_second = r_held_second;
        if (w_s1_fire) begin
            if (!w_c_inpk) begin
                if (w_is_head) begin
                    n_inpk[w_ch]  = 1'b1;
                    n_cnt[w_ch]   = '0;
                    n_phase[w_ch] = PH_SKIP1;
                    n_acc[w_ch]   = '0;
                    n_neg[w_ch]   = 1'b0;
                    n_mask[w_ch]  = '0;
                end
            end else if (!w_is_tail) begin
                // payload past the buffer depth is dropped
                if (w_has_room) begin
                    n_cnt[w_ch]        = w_c_cnt + CNT_W'(1);
                    n_phase[w_ch]      = f_ph;
                    n_acc[w_ch]        = f_acc;
                    n_neg[w_ch]        = f_neg;
                    n_mask[w_ch]       = f_mask;
                    n_pend_first[w_ch] = f_pfirst;
                    n_pend_second      = f_psecond;
                end
            end else begin
                n_inpk[w_ch]       = 1'b0;
                n_phase[w_ch]      = f_ph;
                n_acc[w_ch]        = f_acc;
                n_neg[w_ch]        = f_neg;
                n_mask[w_ch]       = f_mask;
                n_pend_first[w_ch] = f_pfirst;
                n_pend_second      = f_psecond;
                // short packets leave the held values alone
                if (w_long_enough) begin
                    n_held_first[w_ch] = w_new_first;
                    if (!w_ch) begin
                        n_held_second = w_new_second;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inpk          <= '0;
            r_cnt           <= '0;
            r_phase[0]      <= PH_SKIP1;
            r_phase[1]      <= PH_SKIP1;
            r_acc           <= '0;
            r_neg           <= '0;
            r_mask          <= '0;
            r_pend_first    <= '0;
            r_pend_second   <= '0;
            r_held_first[0] <= '0;
            r_held_first[1] <= '1;
            r_held_second   <= '0;
        end else begin
            r_inpk        <= n_inpk;
            r_cnt         <= n_cnt;
            r_phase       <= n_phase;
            r_acc         <= n_acc;
            r_neg         <= n_neg;
            r_mask        <= n_mask;
            r_pend_first  <= n_pend_first;
            r_pend_second <= n_pend_second;
            r_held_first  <= n_held_first;
            r_held_second <= n_held_second;
        end
    end

    // ---------------------------------------------------------------- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_s1_fire && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_s1_fire && w_emit) begin
            r_out_ch     <= w_ch;
            r_out_first  <= w_res_first;
            r_out_second <= w_res_second;
            r_out_nf     <= w_res_nf;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.source_channel = r_out_ch;
    assign o_res.first_value    = r_out_first;
    assign o_res.second_value   = r_out_second;
    assign o_res.fields_parsed  = r_out_nf;

    // ---------------------------------------------------------------- assertions
`include "framed_ascii_decimal_receiver_assert.svh"

    `FADR_ASSERT_NXT(a_emit_loads_result, w_s1_fire && w_emit, r_out_valid && (r_out_ch == $past(w_ch)), "result word not loaded from tail")
    `FADR_ASSERT_IMP(a_chan_one_shape, r_out_valid && r_out_ch, (r_out_second == '0) && (r_out_nf <= 2'd1), "bad channel one result")
    `FADR_ASSERT_IMP(a_cnt_bound, 1'b1, (r_cnt[0] <= CNT_MAX) && (r_cnt[1] <= CNT_MAX), "payload count past buffer depth")
    `FADR_ASSERT_NXT(a_word_kept, r_s1_valid && !w_s1_fire, r_s1_valid && $stable(r_s1_byte) && $stable(r_s1_ch), "held word lost")

endmodule

>>> sim/testbench.sv
// testbench of the framed ascii decimal receiver: framed packets checked against a local parser
module testbench;

    localparam int unsigned BYTE_W               = fadr_pkg::BYTE_W;
    localparam int unsigned FIRST_W              = fadr_pkg::FIRST_W;
    localparam int unsigned VALUE_W              = fadr_pkg::VALUE_W;
    localparam int unsigned NFIELD_W             = fadr_pkg::NFIELD_W;
    localparam int unsigned APB_DATA_W           = fadr_pkg::APB_DATA_W;
    localparam int unsigned APB_ADDR_W           = fadr_pkg::APB_ADDR_W;
    localparam int unsigned BUFFER_DEPTH_DEFAULT = fadr_pkg::BUFFER_DEPTH_DEFAULT;
    localparam logic [BYTE_W-1:0] OFFSET_RESET   = fadr_pkg::OFFSET_RESET;

    // register indexes, byte address is 4 times the index
    localparam int unsigned REG_HEAD_ZERO    = 0;
    localparam int unsigned REG_TAIL_ZERO    = 1;
    localparam int unsigned REG_HEAD_ONE     = 2;
    localparam int unsigned REG_TAIL_ONE     = 3;
    localparam int unsigned REG_FIRST_OFFSET = 4;
    localparam int unsigned REG_UNMAPPED     = 7;

    localparam int unsigned MIN_KEPT_ZERO = 3;
    localparam int unsigned MIN_KEPT_ONE  = 2;
    localparam int unsigned KEEP_LIMIT    = BUFFER_DEPTH_DEFAULT;
    localparam int unsigned MAG_LIMIT     = 32768;
    localparam int unsigned PHASE_COUNT   = 6;
    localparam int unsigned PHASE_WORDS   = 210;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned LIMIT_TIME    = 8 * 200_000;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2c;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    // scanf-like progress through "int" or "int,int"
    typedef enum logic [2:0] {
        SCAN_SKIP_A, SCAN_SIGN_A, SCAN_DIGITS_A,
        SCAN_SKIP_B, SCAN_SIGN_B, SCAN_DIGITS_B, SCAN_DONE
    } t_scan_phase;

    typedef struct {
        logic                       chan;
        logic signed [FIRST_W-1:0]  first;
        logic signed [VALUE_W-1:0]  second;
        logic [NFIELD_W-1:0]        nfields;
    } t_packet_result;

    typedef struct {
        logic                   chan;
        logic [BYTE_W-1:0]      rx;
        bit                     typed;
        t_packet_result         want;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    fadr_rx_if  rx_bus ();
    fadr_res_if res_bus ();

    framed_ascii_decimal_receiver u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // parser copy: register settings and per-channel framing state
    logic [BYTE_W-1:0]  cfg_head [2];
    logic [BYTE_W-1:0]  cfg_tail [2];
    logic [BYTE_W-1:0]  cfg_offset;
    bit                 in_frame [2];
    int unsigned        kept [2];
    t_scan_phase        scan [2];
    int unsigned        mag [2];
    bit                 neg [2];
    int                 held_first [2];
    int                 held_second;
    int                 pend_first [2];
    int                 pend_second;
    logic [1:0]         pend_mask [2];

    t_packet_result     expected_results [$];
    t_stim_row          stim_rows [$];
    logic [BYTE_W-1:0]  bytes0 [$];
    logic [BYTE_W-1:0]  bytes1 [$];
    int unsigned        mismatches = 0;
    bit                 steady = 1'b0;
    bit                 hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_TIME);
        $display("** framed_ascii_decimal_receiver: FAILED **");
        $finish;
    end

    function automatic bit is_space(input logic [BYTE_W-1:0] b);
        return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0d);
    endfunction

    function automatic bit is_digit(input logic [BYTE_W-1:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic void clear_parser();
        cfg_head[0] = '0;
        cfg_head[1] = '0;
        cfg_tail[0] = '0;
        cfg_tail[1] = '0;
        cfg_offset  = OFFSET_RESET;
        for (int c = 0; c < 2; c++) begin
            in_frame[c]  = 1'b0;
            kept[c]      = 0;
            scan[c]      = SCAN_SKIP_A;
            mag[c]       = 0;
            neg[c]       = 1'b0;
            pend_first[c] = 0;
            pend_mask[c] = '0;
        end
        held_first[0] = 0;
        held_first[1] = -1;
        held_second   = 0;
        pend_second   = 0;
    endfunction

    // signed value of the number in progress, int16 saturation
    function automatic int signed_value(input int c);
        if (neg[c])
            return -int'(mag[c]);
        return (mag[c] > 32767) ? 32767 : int'(mag[c]);
    endfunction

    function automatic void scan_byte(input int c, input logic [BYTE_W-1:0] b);
        int unsigned acc;
        case (scan[c])
            SCAN_SKIP_A, SCAN_SKIP_B: begin
                if (!is_space(b)) begin
                    if (b == CH_PLUS || b == CH_MINUS) begin
                        neg[c]  = (b == CH_MINUS);
                        scan[c] = (scan[c] == SCAN_SKIP_A) ? SCAN_SIGN_A : SCAN_SIGN_B;
                    end else if (is_digit(b)) begin
                        mag[c]  = b - CH_ZERO;
                        scan[c] = (scan[c] == SCAN_SKIP_A) ? SCAN_DIGITS_A : SCAN_DIGITS_B;
                    end else begin
                        scan[c] = SCAN_DONE;
                    end
                end
            end
            SCAN_SIGN_A, SCAN_SIGN_B: begin
                if (is_digit(b)) begin
                    mag[c]  = b - CH_ZERO;
                    scan[c] = (scan[c] == SCAN_SIGN_A) ? SCAN_DIGITS_A : SCAN_DIGITS_B;
                end else begin
                    scan[c] = SCAN_DONE;
                end
            end
            SCAN_DIGITS_A, SCAN_DIGITS_B: begin
                if (is_digit(b)) begin
                    // magnitude sticks at 32768 once it overflows
                    acc    = mag[c] * 10 + (b - CH_ZERO);
                    mag[c] = (acc > MAG_LIMIT) ? MAG_LIMIT : acc;
                end else if (scan[c] == SCAN_DIGITS_A) begin
                    pend_first[c] = signed_value(c);
                    pend_mask[c][0] = 1'b1;
                    // channel 0 needs the comma right after the first number
                    if (c == 0 && b == CH_COMMA) begin
                        scan[c] = SCAN_SKIP_B;
                        mag[c]  = 0;
                        neg[c]  = 1'b0;
                    end else begin
                        scan[c] = SCAN_DONE;
                    end
                end else begin
                    pend_second = signed_value(c);
                    pend_mask[c][1] = 1'b1;
                    scan[c] = SCAN_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    // advance the parser copy by one accepted word, 1 when it yields a result
    function automatic bit predict_word(input logic ch, input logic [BYTE_W-1:0] b,
                                        output t_packet_result r);
        int c;
        c = ch;
        r = '{chan: ch, first: '0, second: '0, nfields: '0};
        if (!in_frame[c]) begin
            if (b == cfg_head[c]) begin
                in_frame[c]  = 1'b1;
                kept[c]      = 0;
                scan[c]      = SCAN_SKIP_A;
                mag[c]       = 0;
                neg[c]       = 1'b0;
                pend_mask[c] = '0;
            end
            return 1'b0;
        end
        if (b != cfg_tail[c]) begin
            // payload past the buffer depth is dropped unparsed
            if (kept[c] < KEEP_LIMIT) begin
                kept[c]++;
                scan_byte(c, b);
            end
            return 1'b0;
        end
        // the tail ends the text like a zero byte
        scan_byte(c, CH_NUL);
        in_frame[c] = 1'b0;
        if (kept[c] < (c != 0 ? MIN_KEPT_ONE : MIN_KEPT_ZERO))
            return 1'b0;
        if (pend_mask[c][0]) begin
            held_first[c] = pend_first[c];
            r.nfields++;
        end
        if (c == 0 && pend_mask[c][1]) begin
            held_second = pend_second;
            r.nfields++;
        end
        if (c == 0) begin
            r.first  = FIRST_W'(held_first[0] - int'(cfg_offset));
            r.second = VALUE_W'(held_second);
        end else begin
            r.first  = FIRST_W'(held_first[1]);
            r.second = '0;
        end
        return 1'b1;
    endfunction

    function automatic void add_row(input logic ch, input logic [BYTE_W-1:0] b,
                                    input bit typed = 1'b0,
                                    input logic signed [FIRST_W-1:0] first = '0,
                                    input logic signed [VALUE_W-1:0] second = '0,
                                    input logic [NFIELD_W-1:0] nfields = '0);
        t_stim_row row;
        row.chan  = ch;
        row.rx    = b;
        row.typed = typed;
        row.want  = '{chan: ch, first: first, second: second, nfields: nfields};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_text(input logic ch, input string s);
        for (int k = 0; k < s.len(); k++)
            add_row(ch, s[k]);
    endfunction

    function automatic void put(input bit ch, input logic [BYTE_W-1:0] b);
        if (ch)
            bytes1.push_back(b);
        else
            bytes0.push_back(b);
    endfunction

    function automatic logic [BYTE_W-1:0] junk_byte();
        string pool;
        int unsigned roll;
        pool = " +-,09x\t";
        roll = $urandom_range(9);
        if (roll == 0)
            return CH_NUL;
        if (roll == 1)
            return 8'($urandom_range(255));
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    // optional whitespace, optional sign, then digits, sometimes enough to overflow
    function automatic void put_number(input bit ch);
        int unsigned sign_roll;
        int unsigned ndig;
        if ($urandom_range(3) == 0)
            put(ch, $urandom_range(1) ? CH_SPACE : 8'($urandom_range(9, 13)));
        sign_roll = $urandom_range(3);
        if (sign_roll == 0)
            put(ch, CH_PLUS);
        else if (sign_roll == 1)
            put(ch, CH_MINUS);
        ndig = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
        repeat (ndig) put(ch, CH_ZERO + 8'($urandom_range(9)));
    endfunction

    // queue one packet, or a little line noise, for a channel
    function automatic void build_packet(input bit ch);
        int unsigned roll;
        int unsigned n;
        roll = $urandom_range(99);
        if (roll < 10) begin
            n = $urandom_range(1, 4);
            repeat (n) put(ch, 8'($urandom_range(255)));
        end else begin
            put(ch, cfg_head[ch]);
            if (roll < 75) begin
                put_number(ch);
                if (!ch && $urandom_range(9) != 0) begin
                    put(ch, CH_COMMA);
                    put_number(ch);
                end
                if ($urandom_range(4) == 0)
                    put(ch, junk_byte());
            end else if (roll < 88) begin
                n = $urandom_range(0, 6);
                repeat (n) put(ch, junk_byte());
            end else if (roll < 94) begin
                // long lead-in so the number straddles the buffer depth
                n = $urandom_range(50, 70);
                repeat (n) put(ch, CH_SPACE);
                put_number(ch);
                put(ch, CH_COMMA);
                put_number(ch);
            end else begin
                n = $urandom_range(0, 2);
                repeat (n) put(ch, CH_ZERO + 8'($urandom_range(9)));
            end
            put(ch, cfg_tail[ch]);
        end
    endfunction

    function automatic logic [BYTE_W-1:0] pick_delim();
        string marks;
        marks = "<>[]{}|#$@!~*^&";
        if ($urandom_range(99) < 80)
            return marks[$urandom_range(marks.len() - 1)];
        return 8'($urandom_range(255));
    endfunction

    // offer one word, return at the edge that takes it
    task automatic send_word(input logic ch, input logic [BYTE_W-1:0] b);
        if (!steady && $urandom_range(99) < 6) begin
            rx_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.channel <= ch;
        rx_bus.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_bus.ready) @(posedge i_clk);
    endtask

    // setup then access phase; psel stays up for back-to-back writes
    task automatic write_reg(input int unsigned idx, input logic [BYTE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * idx);
        pwdata  <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_HEAD_ZERO:    cfg_head[0] = value;
            REG_TAIL_ZERO:    cfg_tail[0] = value;
            REG_HEAD_ONE:     cfg_head[1] = value;
            REG_TAIL_ONE:     cfg_tail[1] = value;
            REG_FIRST_OFFSET: cfg_offset  = value;
            default: ;
        endcase
    endtask

    // wait for every pending result, then let the pipeline empty out
    task automatic settle();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_setting(input int p);
        logic [BYTE_W-1:0] h0, t0, h1, t1, off;
        case (p)
            0: begin
                h0 = "{"; t0 = "}"; h1 = "["; t1 = "]"; off = OFFSET_RESET;
            end
            1: begin
                h0 = 8'h00; t0 = 8'hff; h1 = 8'h00; t1 = 8'hff; off = 8'hff;
            end
            2: begin
                h0 = 8'hff; t0 = 8'h00; h1 = 8'hff; t1 = 8'h00; off = 8'h00;
            end
            3: begin
                // head equal to tail: one byte both opens and closes
                h0 = "#"; t0 = "#"; h1 = "$"; t1 = "$"; off = 8'($urandom_range(255));
            end
            default: begin
                h0 = pick_delim(); t0 = pick_delim();
                h1 = pick_delim(); t1 = pick_delim();
                off = 8'($urandom_range(255));
            end
        endcase
        write_reg(REG_HEAD_ZERO, h0);
        write_reg(REG_TAIL_ZERO, t0);
        write_reg(REG_HEAD_ONE, h1);
        write_reg(REG_TAIL_ONE, t1);
        write_reg(REG_FIRST_OFFSET, off);
        // unmapped index must leave every setting alone
        write_reg(REG_UNMAPPED, 8'($urandom_range(255)));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // interleave packets of both channels until enough words have mattered
    task automatic run_phase(input int p);
        int unsigned counted;
        bit ch;
        bit paused;
        bit held;
        logic [BYTE_W-1:0] b;
        t_packet_result got;
        counted = 0;
        paused  = 1'b0;
        held    = 1'b0;
        bytes0.delete();
        bytes1.delete();
        steady = (p == 2);
        while (counted < PHASE_WORDS) begin
            ch = 1'($urandom_range(1));
            if (ch ? bytes1.size() == 0 : bytes0.size() == 0)
                build_packet(ch);
            b = ch ? bytes1.pop_front() : bytes0.pop_front();
            if (in_frame[ch] || b == cfg_head[ch])
                counted++;
            if (p == 3 && !paused && counted >= PHASE_WORDS / 2) begin
                // sender goes quiet until every result is back
                paused = 1'b1;
                rx_bus.valid <= 1'b0;
                do @(posedge i_clk); while (expected_results.size() != 0);
            end
            if (p == 4 && !held && counted >= 40) begin
                // receiver holds off while words keep coming
                held = 1'b1;
                hold_req = 1'b1;
            end
            send_word(ch, b);
            if (predict_word(ch, b, got))
                expected_results.push_back(got);
        end
        rx_bus.valid <= 1'b0;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        res_bus.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            res_bus.ready <= steady || ($urandom_range(99) >= 6);
        end
    end

    // every taken result word is compared with the oldest expectation
    always @(posedge i_clk) begin
        t_packet_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: channel %0d first %0d",
                       res_bus.source_channel, res_bus.first_value);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (res_bus.source_channel !== want.chan) begin
                    $error("source_channel: expected %0d, got %0d",
                           want.chan, res_bus.source_channel);
                    mismatches++;
                end
                if (res_bus.first_value !== want.first) begin
                    $error("first_value: expected %0d, got %0d",
                           want.first, res_bus.first_value);
                    mismatches++;
                end
                if (res_bus.second_value !== want.second) begin
                    $error("second_value: expected %0d, got %0d",
                           want.second, res_bus.second_value);
                    mismatches++;
                end
                if (res_bus.fields_parsed !== want.nfields) begin
                    $error("fields_parsed: expected %0d, got %0d",
                           want.nfields, res_bus.fields_parsed);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_packet_result got;
        bit made;
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        rx_bus.valid   <= 1'b0;
        rx_bus.channel <= 1'b0;
        rx_bus.rx_byte <= '0;
        clear_parser();

        // directed words at reset settings: both channels framed by zero bytes
        add_row(1'b1, CH_NUL);
        add_text(1'b1, "xy");
        // nothing parses, so the reset hold of minus one comes out
        add_row(1'b1, CH_NUL, 1'b1, -17'sd1, 16'sd0, 2'd0);
        add_row(1'b0, CH_NUL);
        add_text(1'b0, "-99999,9");
        add_row(1'b1, CH_NUL);
        add_text(1'b1, "99999");
        // saturated negative minus the reset offset of 45
        add_row(1'b0, CH_NUL, 1'b1, -17'sd32813, 16'sd9, 2'd2);
        add_row(1'b1, CH_NUL, 1'b1, 17'sd32767, 16'sd0, 2'd1);
        // two payload bytes on channel 0 are too short for a result
        add_row(1'b0, CH_NUL);
        add_text(1'b0, "12");
        add_row(1'b0, CH_NUL);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[k]) begin
            send_word(stim_rows[k].chan, stim_rows[k].rx);
            made = predict_word(stim_rows[k].chan, stim_rows[k].rx, got);
            if (stim_rows[k].typed)
                expected_results.push_back(stim_rows[k].want);
            else if (made)
                expected_results.push_back(got);
        end
        rx_bus.valid <= 1'b0;

        for (int p = 0; p < PHASE_COUNT; p++) begin
            settle();
            load_setting(p);
            run_phase(p);
        end
        settle();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("** framed_ascii_decimal_receiver: PASSED **");
        else
            $display("** framed_ascii_decimal_receiver: FAILED **");
        $finish;
    end

endmodule
